// ===== design/tgc_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch gesture classifier package
// Shared widths, gesture codes, configuration register indexes, their reset values and action codes.
// ----------------------------------------------------------------------------
package tgc_pkg;

  // Field widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned KindW  = 3;
  localparam int unsigned RunW   = 8;
  localparam int unsigned HoldW  = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Gesture codes reported on event_kind
  localparam logic [KindW-1:0] KIND_NONE      = 3'd0;
  localparam logic [KindW-1:0] KIND_SHORT     = 3'd1;
  localparam logic [KindW-1:0] KIND_DOUBLE    = 3'd2;
  localparam logic [KindW-1:0] KIND_LONG      = 3'd3;
  localparam logic [KindW-1:0] KIND_VERY_LONG = 3'd4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_STABLE_SAMPLES    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DOUBLE_WINDOW_MS  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LONG_HOLD_MS      = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_VERY_LONG_HOLD_MS = 2'd3;

  // Reset values of the configuration registers
  localparam logic [RunW-1:0]  STABLE_SAMPLES_RST    = 8'd5;
  localparam logic [HoldW-1:0] DOUBLE_WINDOW_MS_RST  = 16'd300;
  localparam logic [HoldW-1:0] LONG_HOLD_MS_RST      = 16'd1000;
  localparam logic [HoldW-1:0] VERY_LONG_HOLD_MS_RST = 16'd10000;

  // Action codes
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

endpackage

// ===== design/touch_gesture_classifier.sv =====
// ----------------------------------------------------------------------------
// Touch gesture classifier
// Debounces sampled touch levels and classifies short, double, long and
// very long presses, latching the last gesture until cleared.
// ----------------------------------------------------------------------------
// Each input beat is either a sample (level plus millisecond timestamp) or a
// clear of the latched event. A beat is consumed in the cycle it is accepted:
// the debounce and gesture state is updated at that edge and the result beat
// (pending flag, gesture kind, debounced touch) appears in the output register
// on the next cycle. One beat per clock is sustained while results are taken;
// the rate is set by the state update loop, which holds four 32-bit wrapping
// time subtractions and their compares. Input is back-pressured only while the
// output register holds a result that has not been taken. Configuration
// writes are always accepted and should be done while the block is idle.
// ----------------------------------------------------------------------------
module touch_gesture_classifier import tgc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // Configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  // Input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                action,
  input  logic                touch_level,
  input  logic [TimeW-1:0]    now_ms,
  // Output channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic                event_pending,
  output logic [KindW-1:0]    event_kind,
  output logic                touching
);

  // Configuration registers
  logic [RunW-1:0]  stable_samples;
  logic [HoldW-1:0] double_window_ms;
  logic [HoldW-1:0] long_hold_ms;
  logic [HoldW-1:0] very_long_hold_ms;

  // Gesture state
  logic             candidate_level, candidate_level_next;
  logic [RunW-1:0]  stable_run, stable_run_next;
  logic             reported_level, reported_level_next;
  logic             held, held_next;
  logic [TimeW-1:0] press_time, press_time_next;
  logic [TimeW-1:0] release_time, release_time_next;
  logic             click_waiting, click_waiting_next;
  logic             long_done, long_done_next;
  logic             very_long_done, very_long_done_next;
  logic [KindW-1:0] latched_kind, latched_kind_next;
  logic             latched_pending, latched_pending_next;

  logic in_fire;
  logic cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign in_ready  = ~out_valid | out_ready;
  assign in_fire   = in_valid & in_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      stable_samples    <= STABLE_SAMPLES_RST;
      double_window_ms  <= DOUBLE_WINDOW_MS_RST;
      long_hold_ms      <= LONG_HOLD_MS_RST;
      very_long_hold_ms <= VERY_LONG_HOLD_MS_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_STABLE_SAMPLES:    stable_samples    <= cfg_data[RunW-1:0];
        REG_DOUBLE_WINDOW_MS:  double_window_ms  <= cfg_data;
        REG_LONG_HOLD_MS:      long_hold_ms      <= cfg_data;
        REG_VERY_LONG_HOLD_MS: very_long_hold_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next-state logic: clear, else debounce, edge handling, then the hold and window
  // checks in order, each seeing the updates of the ones before it.
  logic [TimeW-1:0] since_press;
  logic [TimeW-1:0] since_release;
  logic             edge_seen;

  always_comb begin
    candidate_level_next = candidate_level;
    stable_run_next      = stable_run;
    reported_level_next  = reported_level;
    held_next            = held;
    press_time_next      = press_time;
    release_time_next    = release_time;
    click_waiting_next   = click_waiting;
    long_done_next       = long_done;
    very_long_done_next  = very_long_done;
    latched_kind_next    = latched_kind;
    latched_pending_next = latched_pending;
    since_press          = '0;
    since_release        = '0;
    edge_seen            = 1'b0;

    if (action == ACT_CLEAR) begin
      latched_pending_next = 1'b0;
      latched_kind_next    = KIND_NONE;
    end else begin
      // Run counter saturates at the stable sample count.
      if (touch_level == candidate_level) begin
        if (stable_run < stable_samples) begin
          stable_run_next = stable_run + RunW'(1);
        end
      end else begin
        candidate_level_next = touch_level;
        stable_run_next      = RunW'(1);
      end

      edge_seen = (stable_run_next >= stable_samples) &&
                  (candidate_level_next != reported_level);

      // Debounced press or release
      if (edge_seen) begin
        reported_level_next = candidate_level_next;
        if (candidate_level_next) begin
          held_next           = 1'b1;
          press_time_next     = now_ms;
          long_done_next      = 1'b0;
          very_long_done_next = 1'b0;
          since_release       = now_ms - release_time;
          if ((since_release < TimeW'(double_window_ms)) && click_waiting) begin
            click_waiting_next   = 1'b0;
            latched_kind_next    = KIND_DOUBLE;
            latched_pending_next = 1'b1;
          end else begin
            click_waiting_next = 1'b1;
          end
        end else begin
          held_next         = 1'b0;
          release_time_next = now_ms;
          since_press       = now_ms - press_time;
          if (since_press >= TimeW'(long_hold_ms)) begin
            latched_kind_next    = KIND_LONG;
            latched_pending_next = 1'b1;
            click_waiting_next   = 1'b0;
            long_done_next       = 1'b1;
          end
        end
      end

      since_press   = now_ms - press_time_next;
      since_release = now_ms - release_time_next;

      // Very long hold
      if (held_next && !very_long_done_next &&
          (since_press >= TimeW'(very_long_hold_ms))) begin
        latched_kind_next    = KIND_VERY_LONG;
        latched_pending_next = 1'b1;
        click_waiting_next   = 1'b0;
        long_done_next       = 1'b1;
        very_long_done_next  = 1'b1;
      end

      // Long hold while still pressed
      if (held_next && !long_done_next &&
          (since_press >= TimeW'(long_hold_ms))) begin
        latched_kind_next    = KIND_LONG;
        latched_pending_next = 1'b1;
        click_waiting_next   = 1'b0;
        long_done_next       = 1'b1;
      end

      // Lone click whose double window ran out
      if (!held_next && click_waiting_next &&
          (since_release >= TimeW'(double_window_ms))) begin
        latched_kind_next    = KIND_SHORT;
        latched_pending_next = 1'b1;
        click_waiting_next   = 1'b0;
      end
    end
  end

  // State update on each accepted input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      candidate_level <= 1'b0;
      stable_run      <= '0;
      reported_level  <= 1'b0;
      held            <= 1'b0;
      press_time      <= '0;
      release_time    <= '0;
      click_waiting   <= 1'b0;
      long_done       <= 1'b0;
      very_long_done  <= 1'b0;
      latched_kind    <= KIND_NONE;
      latched_pending <= 1'b0;
    end else if (in_fire) begin
      candidate_level <= candidate_level_next;
      stable_run      <= stable_run_next;
      reported_level  <= reported_level_next;
      held            <= held_next;
      press_time      <= press_time_next;
      release_time    <= release_time_next;
      click_waiting   <= click_waiting_next;
      long_done       <= long_done_next;
      very_long_done  <= very_long_done_next;
      latched_kind    <= latched_kind_next;
      latched_pending <= latched_pending_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      event_pending <= latched_pending_next;
      event_kind    <= latched_kind_next;
      touching      <= held_next;
    end
  end

endmodule

// ===== design/tgc_checker.sv =====
// ----------------------------------------------------------------------------
// Touch gesture classifier checker
// Port-level assertions on the classifier, bound into the classifier module.
// ----------------------------------------------------------------------------
module tgc_checker import tgc_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             action,
  input logic             out_valid,
  input logic             out_ready,
  input logic             event_pending,
  input logic [KindW-1:0] event_kind,
  input logic             touching
);

  // Every accepted input beat yields a result beat on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted input beat produced no result beat");

  // A clear beat reports no pending event.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action == ACT_CLEAR) |=>
      (!event_pending && event_kind == KIND_NONE))
    else $error("clear beat left an event latched");

  // Pending flag and gesture kind agree.
  a_pending_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_pending == (event_kind != KIND_NONE)))
    else $error("pending flag disagrees with event kind");

  // A stalled result beat holds its payload.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(event_pending) && $stable(event_kind) && $stable(touching)))
    else $error("stalled result beat changed");

endmodule

bind touch_gesture_classifier tgc_checker u_tgc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .action        (action),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .event_pending (event_pending),
  .event_kind    (event_kind),
  .touching      (touching)
);
